// ----- sv/lfvc_pkg.sv -----
// Shared types and constants of the frame vote classifier.
// Holds the state enum, default coefficients and the exp table builder.
// No dependencies.
package lfvc_pkg;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_MAC,
        S_MAX,
        S_EXP,
        S_DVC,
        S_DVCW,
        S_ACC,
        S_DVM,
        S_DVMW,
        S_CLIP,
        S_OUT
    } t_state;

    localparam int COEF_W        = 24;
    localparam int FEAT_W        = 16;
    localparam int IN_FEATS      = 6;
    localparam int SUM_W         = 56;
    localparam int EXP_MAX_DEPTH = 1024;
    localparam int EXP_AW        = 10;
    localparam int QUOT_W        = 49;
    localparam logic [63:0] EXP_RATIO = 64'd4034748382;
    localparam logic [QUOT_W-1:0] CONF_NUM = QUOT_W'(64'h1_0000_0000_0000);
    localparam logic [1:0] CLASS_UNKNOWN = 2'd3;

    typedef logic [32:0] t_exp_tab [EXP_MAX_DEPTH];

    localparam logic signed [COEF_W-1:0] DEF_W [18] = '{
        24'sd12687,   24'sd90960,   24'sd12932,   24'sd12713,   -24'sd66677, 24'sd18496,
        -24'sd8047,   -24'sd186470, 24'sd18460,   -24'sd1353,   24'sd108364, -24'sd19838,
        -24'sd79882,  -24'sd52219,  -24'sd189196, -24'sd107170, 24'sd152765, -24'sd83694
    };
    localparam logic signed [COEF_W-1:0] DEF_B [3] = '{
        -24'sd422731, 24'sd287471, -24'sd543307
    };

    function automatic logic [COEF_W-1:0] coef_default(input int c, input int f,
                                                       input logic bias);
        logic [COEF_W-1:0] v;
        v = '0;
        if (bias) begin
            if (c < 3) v = DEF_B[c];
        end else if (c < 3 && f < 6) begin
            v = DEF_W[c*6+f];
        end
        return v;
    endfunction

    function automatic t_exp_tab exp_table();
        t_exp_tab    t;
        logic [63:0] e;
        e = 64'd1 << 32;
        for (int i = 0; i < EXP_MAX_DEPTH; i++) begin
            t[i] = e[32:0];
            e = (e * EXP_RATIO + 64'h8000_0000) >> 32;
        end
        return t;
    endfunction

endpackage

// ----- sv/lda_frame_vote_classifier.sv -----
// Top level of the linear frame classifier with clip vote.
// Depends on lfvc_pkg, lfvc_ram and lfvc_div.
//
// channel  | direction | accepts when            | payload
// s_axis   | in        | tvalid & tready         | coef write (tuser=0) or frame (tuser=1)
// m_axis   | out       | tvalid & tready         | frame class, clip decision
// cfg      | in        | i_cfg_wr_en             | confidence threshold
//
// Coefficient writes are taken in the idle state. A frame holds s_axis_tready low
// until its result is loaded into the output register; a last frame also runs the
// mean division and the clip vote. The shared serial divider (one bit per cycle)
// and the single coefficient RAM read port pace this work. After reset the RAM is
// loaded with the trained coefficients, during which s_axis_tready stays low. A
// stalled output holds in its register while the next beat is taken in.
module lda_frame_vote_classifier #(
    parameter int NUM_FEATURES    = 6,
    parameter int NUM_CLASSES_P   = 3,
    parameter int EXP_TABLE_DEPTH = 256
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // coef_index[4:0], coef_value[28:5], feature_0..feature_5[124:29], zero pad
    input  logic [127:0] s_axis_tdata,
    // func
    input  logic         s_axis_tuser,
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // frame_class[1:0], clip_class[3:2], mean_confidence[19:4], zero pad
    output logic [23:0]  m_axis_tdata,
    // clip_valid
    output logic         m_axis_tuser,
    input  logic         i_cfg_wr_en,
    input  logic [15:0]  i_cfg_wr_data
);

    localparam int NF         = NUM_FEATURES;
    localparam int NC         = NUM_CLASSES_P;
    localparam int COEF_DEPTH = NC * NF + NC;
    localparam int AW         = $clog2(COEF_DEPTH);
    localparam int CW         = $clog2(NC);
    localparam int FW         = $clog2(NF + 1);
    localparam int PW         = 40;
    localparam int SW         = PW + $clog2(NF + 1) + 1;
    localparam int TOT_W      = 33 + $clog2(NC);
    localparam int QW         = lfvc_pkg::QUOT_W;
    localparam int CO_W       = lfvc_pkg::COEF_W;
    localparam int FT_W       = lfvc_pkg::FEAT_W;
    localparam int SM_W       = lfvc_pkg::SUM_W;
    localparam lfvc_pkg::t_exp_tab EXP_TAB = lfvc_pkg::exp_table();

    lfvc_pkg::t_state r_state, n_state;

    logic [15:0]               r_thr;
    logic [CW-1:0]             r_ic;
    logic [FW-1:0]             r_if;
    logic                      r_issue_done;
    logic                      r_s1_vld, r_s1_bias, r_s2_vld, r_s2_bias;
    logic [CW-1:0]             r_s1_c, r_s2_c;
    logic [FW-1:0]             r_s1_f;
    logic signed [PW-1:0]      r_prod;
    logic signed [SW-1:0]      r_acc;
    logic signed [SW-1:0]      r_score [NC];
    logic signed [FT_W-1:0]    r_feat [lfvc_pkg::IN_FEATS];
    logic                      r_last;
    logic [CW-1:0]             r_cnt;
    logic signed [SW-1:0]      r_best;
    logic [CW-1:0]             r_cls;
    logic [TOT_W-1:0]          r_total;
    logic [15:0]               r_conf;
    logic [31:0]               r_csum;
    logic [15:0]               r_frames;
    logic signed [SM_W-1:0]    r_ssum [NC];
    logic signed [SM_W-1:0]    n_ssum [NC];
    logic signed [SM_W-1:0]    r_cbest;
    logic [CW-1:0]             r_ccls;
    logic [15:0]               r_mean;
    logic [1:0]                r_clip;
    logic                      r_cv;
    logic                      r_out_vld;
    logic [1:0]                r_o_fc, r_o_cc;
    logic                      r_o_cv;
    logic [15:0]               r_o_mean;

    logic                      iss_bias, iss_last, advance;
    logic [AW-1:0]             iss_addr;
    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    logic [CO_W-1:0]           ram_wdata;
    logic signed [CO_W-1:0]    ram_rdata;
    logic signed [FT_W-1:0]    s1_feat;
    logic signed [PW-1:0]      s1_prod;
    logic                      div_start;
    logic [QW-1:0]             div_num;
    logic [TOT_W-1:0]          div_den;
    logic                      div_done;
    logic [QW-1:0]             div_quot;
    logic [15:0]               quot_sat;
    logic signed [SW-1:0]      cur_score;
    logic [SW-1:0]             diff;
    logic [CW-1:0]             clip_fin;
    logic                      out_load;
    logic                      cnt_last;
    logic [32:0]               csum_add;

    assign iss_bias = (r_if == FW'(NF));
    assign iss_last = iss_bias && (r_ic == CW'(NC - 1));
    assign iss_addr = iss_bias ? AW'(NC * NF) + AW'(r_ic)
                               : AW'(r_ic) * AW'(NF) + AW'(r_if);
    assign advance  = (r_state == lfvc_pkg::S_INIT) ||
                      (r_state == lfvc_pkg::S_MAC && !r_issue_done);
    assign cnt_last = (r_cnt == CW'(NC - 1));
    assign out_load = (r_state == lfvc_pkg::S_OUT) && (!r_out_vld || m_axis_tready);
    assign quot_sat = (|div_quot[QW-1:16]) ? 16'hFFFF : div_quot[15:0];
    assign cur_score = r_score[r_cnt];
    assign diff     = r_best - cur_score;
    assign csum_add = {1'b0, r_csum} + {17'd0, r_conf};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lfvc_pkg::S_INIT: if (iss_last) n_state = lfvc_pkg::S_IDLE;
            lfvc_pkg::S_IDLE: if (s_axis_tvalid && s_axis_tuser) n_state = lfvc_pkg::S_MAC;
            lfvc_pkg::S_MAC: begin
                if (r_issue_done && !r_s1_vld && !r_s2_vld) n_state = lfvc_pkg::S_MAX;
            end
            lfvc_pkg::S_MAX:  if (cnt_last) n_state = lfvc_pkg::S_EXP;
            lfvc_pkg::S_EXP:  if (cnt_last) n_state = lfvc_pkg::S_DVC;
            lfvc_pkg::S_DVC:  n_state = lfvc_pkg::S_DVCW;
            lfvc_pkg::S_DVCW: if (div_done) n_state = lfvc_pkg::S_ACC;
            lfvc_pkg::S_ACC:  n_state = r_last ? lfvc_pkg::S_DVM : lfvc_pkg::S_OUT;
            lfvc_pkg::S_DVM:  n_state = lfvc_pkg::S_DVMW;
            lfvc_pkg::S_DVMW: if (div_done) n_state = lfvc_pkg::S_CLIP;
            lfvc_pkg::S_CLIP: if (cnt_last) n_state = lfvc_pkg::S_OUT;
            lfvc_pkg::S_OUT:  if (out_load) n_state = lfvc_pkg::S_IDLE;
            default:          n_state = lfvc_pkg::S_INIT;
        endcase
    end

    // control outputs
    always_comb begin
        s_axis_tready = (r_state == lfvc_pkg::S_IDLE);
        ram_we        = 1'b0;
        ram_waddr     = iss_addr;
        ram_wdata     = lfvc_pkg::coef_default(int'(r_ic), int'(r_if), iss_bias);
        div_start     = 1'b0;
        div_num       = lfvc_pkg::CONF_NUM;
        div_den       = r_total;
        case (r_state)
            lfvc_pkg::S_INIT: ram_we = 1'b1;
            lfvc_pkg::S_IDLE: begin
                ram_waddr = AW'(s_axis_tdata[4:0]);
                ram_wdata = s_axis_tdata[28:5];
                ram_we    = s_axis_tvalid && !s_axis_tuser &&
                            (int'(s_axis_tdata[4:0]) < COEF_DEPTH);
            end
            lfvc_pkg::S_DVC: div_start = 1'b1;
            lfvc_pkg::S_DVM: begin
                div_start = 1'b1;
                div_num   = QW'(r_csum);
                div_den   = TOT_W'(r_frames);
            end
            default: ;
        endcase
    end

    always_comb begin
        s1_feat = '0;
        if (int'(r_s1_f) < lfvc_pkg::IN_FEATS) s1_feat = r_feat[3'(r_s1_f)];
        s1_prod = s1_feat * ram_rdata;
        if (r_s1_bias) s1_prod = {{(PW-32){ram_rdata[CO_W-1]}}, ram_rdata, 8'd0};
    end

    always_comb begin
        logic signed [SM_W:0] s;
        for (int c = 0; c < NC; c++) begin
            s = {r_ssum[c][SM_W-1], r_ssum[c]} + (SM_W+1)'(r_score[c]);
            if (s[SM_W] != s[SM_W-1]) begin
                n_ssum[c] = s[SM_W] ? {1'b1, {(SM_W-1){1'b0}}} : {1'b0, {(SM_W-1){1'b1}}};
            end else begin
                n_ssum[c] = s[SM_W-1:0];
            end
        end
    end

    assign clip_fin = (r_cnt == '0 || r_ssum[r_cnt] > r_cbest) ? r_cnt : r_ccls;

    lfvc_ram #(
        .WIDTH (CO_W),
        .DEPTH (COEF_DEPTH)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (iss_addr),
        .o_rdata (ram_rdata)
    );

    lfvc_div #(
        .N_W (QW),
        .D_W (TOT_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= lfvc_pkg::S_INIT;
            r_thr        <= 16'd32768;
            r_ic         <= '0;
            r_if         <= '0;
            r_issue_done <= 1'b0;
            r_s1_vld     <= 1'b0;
            r_s2_vld     <= 1'b0;
            r_cnt        <= '0;
            r_csum       <= '0;
            r_frames     <= '0;
            r_out_vld    <= 1'b0;
            for (int c = 0; c < NC; c++) r_ssum[c] <= '0;
        end else begin
            r_state  <= n_state;
            if (i_cfg_wr_en) r_thr <= i_cfg_wr_data;
            r_s1_vld <= (r_state == lfvc_pkg::S_MAC) && !r_issue_done;
            r_s2_vld <= r_s1_vld;
            if (advance) begin
                if (iss_bias) begin
                    r_if <= '0;
                    r_ic <= iss_last ? '0 : r_ic + 1'b1;
                end else begin
                    r_if <= r_if + 1'b1;
                end
                if (iss_last && r_state == lfvc_pkg::S_MAC) r_issue_done <= 1'b1;
            end
            if (r_state == lfvc_pkg::S_IDLE) r_issue_done <= 1'b0;
            if (r_state == lfvc_pkg::S_MAX || r_state == lfvc_pkg::S_EXP ||
                r_state == lfvc_pkg::S_CLIP) begin
                r_cnt <= cnt_last ? '0 : r_cnt + 1'b1;
            end
            if (r_state == lfvc_pkg::S_ACC) begin
                r_csum   <= csum_add[32] ? 32'hFFFF_FFFF : csum_add[31:0];
                r_frames <= (r_frames == 16'hFFFF) ? r_frames : r_frames + 1'b1;
                for (int c = 0; c < NC; c++) r_ssum[c] <= n_ssum[c];
            end
            if (r_state == lfvc_pkg::S_CLIP && cnt_last) begin
                r_csum   <= '0;
                r_frames <= '0;
                for (int c = 0; c < NC; c++) r_ssum[c] <= '0;
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_s1_c    <= r_ic;
        r_s1_f    <= r_if;
        r_s1_bias <= iss_bias;
        r_s2_c    <= r_s1_c;
        r_s2_bias <= r_s1_bias;
        r_prod    <= s1_prod;
        case (r_state)
            lfvc_pkg::S_IDLE: begin
                for (int f = 0; f < lfvc_pkg::IN_FEATS; f++) begin
                    r_feat[f] <= s_axis_tdata[29 + f*FT_W +: FT_W];
                end
                r_last  <= s_axis_tlast;
                r_acc   <= '0;
                r_total <= '0;
                r_mean  <= '0;
                r_clip  <= '0;
                r_cv    <= 1'b0;
            end
            lfvc_pkg::S_MAC: begin
                if (r_s2_vld) begin
                    if (r_s2_bias) begin
                        r_score[r_s2_c] <= r_acc + SW'(r_prod);
                        r_acc           <= '0;
                    end else begin
                        r_acc <= r_acc + SW'(r_prod);
                    end
                end
            end
            lfvc_pkg::S_MAX: begin
                if (r_cnt == '0 || cur_score > r_best) begin
                    r_best <= cur_score;
                    r_cls  <= r_cnt;
                end
            end
            lfvc_pkg::S_EXP: begin
                if (diff[SW-1:20] < EXP_TABLE_DEPTH) begin
                    r_total <= r_total + TOT_W'(EXP_TAB[diff[20 +: lfvc_pkg::EXP_AW]]);
                end
            end
            lfvc_pkg::S_DVCW: if (div_done) r_conf <= quot_sat;
            lfvc_pkg::S_DVMW: if (div_done) r_mean <= quot_sat;
            lfvc_pkg::S_CLIP: begin
                r_cbest <= (r_cnt == '0 || r_ssum[r_cnt] > r_cbest) ? r_ssum[r_cnt] : r_cbest;
                r_ccls  <= clip_fin;
                if (cnt_last) begin
                    r_clip <= (r_mean < r_thr) ? lfvc_pkg::CLASS_UNKNOWN : 2'(clip_fin);
                    r_cv   <= 1'b1;
                end
            end
            default: ;
        endcase
        if (out_load) begin
            r_o_fc   <= 2'(r_cls);
            r_o_cc   <= r_clip;
            r_o_cv   <= r_cv;
            r_o_mean <= r_mean;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {4'd0, r_o_mean, r_o_cc, r_o_fc};
    assign m_axis_tuser  = r_o_cv;

endmodule

// ----- sv/lfvc_ram.sv -----
// Generic simple dual-port RAM with registered read.
// No dependencies.
module lfvc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 21
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/lfvc_div.sv -----
// Restoring divider, one quotient bit per cycle.
// No dependencies.
module lfvc_div #(
    parameter int N_W = 49,
    parameter int D_W = 35
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [N_W-1:0] i_num,
    input  logic [D_W-1:0] i_den,
    output logic           o_done,
    output logic [N_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(N_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [D_W-1:0]   r_rem;
    logic [D_W-1:0]   r_den;
    logic [N_W-1:0]   r_q;
    logic [D_W:0]     rem_sh;
    logic [D_W:0]     diff;
    logic             ge;

    assign rem_sh = {r_rem, r_q[N_W-1]};
    assign ge     = rem_sh >= {1'b0, r_den};
    assign diff   = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(N_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= ge ? diff[D_W-1:0] : rem_sh[D_W-1:0];
            r_q   <= {r_q[N_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule
